// ===== rtl/core/tdb_pkg.sv =====
package tdb_pkg;

   localparam int SIZE_W  = 24;
   localparam int TOL_W   = 16;
   localparam int DELTA_W = 23;
   localparam int DIST_W  = 23;
   localparam int BEAR_W  = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam int SQ_W       = 2 * DELTA_W;
   localparam int SQRT_STEPS = 24;
   localparam int ROOT_W     = SQ_W + 2;

   localparam int CORDIC_SHIFT  = 16;
   localparam int CX_W          = DELTA_W + CORDIC_SHIFT + 3;
   localparam int CZ_W          = 28;
   localparam int ANG_TABLE_LEN = 24;
   localparam int HALF_PI_Q24   = 26353589;
   localparam int BEARING_LIMIT = 25736;
   localparam int BEARING_SHIFT = 11;
   localparam int BEARING_HALF  = 1024;

   localparam int ATAN_Q24 [ANG_TABLE_LEN] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   localparam int RSP_FIELD_W = 2 * DELTA_W + DIST_W + BEAR_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;
   localparam int RSP_USER_W  = 2;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [TOL_W-1:0]  tol;
   } cfg_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [DIST_W-1:0]         distance;
      logic signed [BEAR_W-1:0]  bearing;
      logic                      same_point;
      logic                      in_range;
   } rsp_type;

endpackage

// ===== rtl/core/tdb_pipe.sv =====
module tdb_pipe
   import tdb_pkg::*;
#(
   parameter int COORD_WIDTH   = 24,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] source_x,
   input  logic signed [COORD_WIDTH-1:0] source_y,
   input  logic signed [COORD_WIDTH-1:0] target_x,
   input  logic signed [COORD_WIDTH-1:0] target_y,
   input  cfg_type                       cfg,
   output logic                          out_valid,
   output rsp_type                       out_beat
);

   localparam int CW        = COORD_WIDTH;
   localparam int DW        = CW + 1;
   localparam int IW        = (CW > SIZE_W ? CW : SIZE_W) + 1;
   localparam int MW        = (CW > SIZE_W - 2 ? CW : SIZE_W - 2) + 1;
   localparam int VW        = MW + 1;
   localparam int AW        = (DW > TOL_W ? DW : TOL_W);
   localparam int MOD_STEPS = MW - 1;
   localparam int DIV_W     = MW + SIZE_W;
   localparam int SQ_LAT    = SQRT_STEPS + 3;
   localparam int BEAR_DLY  = SQ_LAT - CORDIC_STAGES - 3;
   localparam int LAT       = MOD_STEPS + 6 + SQ_LAT;

   function automatic logic in_world(input logic signed [CW-1:0] c,
                                     input logic [SIZE_W-1:0]    sz);
      logic signed [IW-1:0] sum;
      sum = IW'(c) + $signed(IW'(sz >> 1));
      return !sum[IW-1] && (sum < $signed(IW'(sz)));
   endfunction

   logic [LAT-1:0]    vld_ff;
   logic [SIZE_W-1:0] size [2];
   logic [SIZE_W-1:0] half [2];

   logic signed [CW-1:0] src_ff [2];
   logic signed [CW-1:0] tgt_ff [2];

   logic signed [DW-1:0] d1_in [2];
   logic signed [DW-1:0] d1_ff [2];
   logic                 ok1_in, ok1_ff;

   logic signed [VW-1:0] v2_in [2];
   logic signed [VW-1:0] v2_ff [2];
   logic [DW-1:0]        ad2_in [2];
   logic [DW-1:0]        ad2_ff [2];
   logic                 ok2_ff;

   logic [MW-1:0]        u_in [2][MOD_STEPS+1];
   logic [MW-1:0]        u_ff [2][MOD_STEPS+1];
   logic [MOD_STEPS:0]   neg_ff [2];
   logic                 same3_in;
   logic [MOD_STEPS:0]   same_m_ff;
   logic [MOD_STEPS:0]   ok_m_ff;

   logic [SIZE_W-1:0]    r_in [2];
   logic [SIZE_W-1:0]    r_ff [2];
   logic                 same_r_ff, ok_r_ff;

   logic signed [DELTA_W-1:0] dl_in [2];
   logic signed [DELTA_W-1:0] dl_ff [2];
   logic                      same_d_ff, ok_d_ff;

   logic signed [SQ_W-1:0] px_in, py_in;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff;
   logic [ROOT_W-1:0]      n_in [SQRT_STEPS+1];
   logic [ROOT_W-1:0]      n_ff [SQRT_STEPS+1];
   logic [ROOT_W-1:0]      rt_in [SQRT_STEPS+1];
   logic [ROOT_W-1:0]      rt_ff [SQRT_STEPS+1];
   rsp_type                res_in [SQ_LAT];
   rsp_type                res_ff [SQ_LAT];

   logic signed [CX_W-1:0]   cx_in [CORDIC_STAGES+1];
   logic signed [CX_W-1:0]   cx_ff [CORDIC_STAGES+1];
   logic signed [CX_W-1:0]   cy_in [CORDIC_STAGES+1];
   logic signed [CX_W-1:0]   cy_ff [CORDIC_STAGES+1];
   logic signed [CZ_W-1:0]   cz_in [CORDIC_STAGES+1];
   logic signed [CZ_W-1:0]   cz_ff [CORDIC_STAGES+1];
   logic                     cf_in;
   logic [CORDIC_STAGES:0]   cf_ff;
   logic signed [BEAR_W-1:0] b_in;
   logic signed [BEAR_W-1:0] b_ff [BEAR_DLY+1];

   always_comb begin
      size[0] = cfg.size_x;
      size[1] = cfg.size_y;
      for (int a = 0; a < 2; a++) begin
         half[a] = size[a] >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[LAT-1];

   // displacement and world bounds
   always_comb begin
      ok1_in = 1'b1;
      for (int a = 0; a < 2; a++) begin
         d1_in[a] = DW'(tgt_ff[a]) - DW'(src_ff[a]);
         ok1_in   = ok1_in & in_world(src_ff[a], size[a]) & in_world(tgt_ff[a], size[a]);
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         v2_in[a]  = VW'(d1_ff[a]) + $signed(VW'(half[a]));
         ad2_in[a] = d1_ff[a][DW-1] ? $unsigned(-d1_ff[a]) : $unsigned(d1_ff[a]);
      end
   end

   assign same3_in = (AW'(ad2_ff[0]) < AW'(cfg.tol)) && (AW'(ad2_ff[1]) < AW'(cfg.tol));

   // restoring remainder, one quotient bit per stage
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         u_in[a][0] = MW'($unsigned(v2_ff[a][VW-1] ? -v2_ff[a] : v2_ff[a]));
         for (int j = 1; j <= MOD_STEPS; j++) begin
            if (DIV_W'(u_ff[a][j-1]) >= (DIV_W'(size[a]) << (MOD_STEPS - j))) begin
               u_in[a][j] = MW'(DIV_W'(u_ff[a][j-1]) - (DIV_W'(size[a]) << (MOD_STEPS - j)));
            end else begin
               u_in[a][j] = u_ff[a][j-1];
            end
         end
      end
   end

   always_comb begin
      logic [SIZE_W-1:0] ue;
      for (int a = 0; a < 2; a++) begin
         ue       = SIZE_W'(u_ff[a][MOD_STEPS]);
         r_in[a]  = (neg_ff[a][MOD_STEPS] && ue != '0) ? size[a] - ue : ue;
         dl_in[a] = DELTA_W'($signed({1'b0, r_ff[a]}) - $signed({1'b0, half[a]}));
      end
   end

   // squared length and square root
   assign px_in = SQ_W'(dl_ff[0]) * SQ_W'(dl_ff[0]);
   assign py_in = SQ_W'(dl_ff[1]) * SQ_W'(dl_ff[1]);

   always_comb begin
      logic [ROOT_W-1:0] sbit;
      logic [ROOT_W-1:0] trial;
      logic [ROOT_W-1:0] dsum;
      n_in[0]  = ROOT_W'(sqx_ff) + ROOT_W'(sqy_ff);
      rt_in[0] = '0;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
         sbit  = ROOT_W'(1) << (2 * (SQRT_STEPS - j));
         trial = rt_ff[j-1] + sbit;
         if (n_ff[j-1] >= trial) begin
            n_in[j]  = n_ff[j-1] - trial;
            rt_in[j] = (rt_ff[j-1] >> 1) + sbit;
         end else begin
            n_in[j]  = n_ff[j-1];
            rt_in[j] = rt_ff[j-1] >> 1;
         end
      end

      res_in[0]            = res_ff[0];
      res_in[0].delta_x    = dl_ff[0];
      res_in[0].delta_y    = dl_ff[1];
      res_in[0].same_point = same_d_ff;
      res_in[0].in_range   = ok_d_ff;
      for (int k = 1; k < SQ_LAT; k++) begin
         res_in[k] = res_ff[k-1];
      end
      dsum = rt_ff[SQRT_STEPS] + ROOT_W'(n_ff[SQRT_STEPS] > rt_ff[SQRT_STEPS]);
      res_in[SQ_LAT-1].distance = (dsum > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum);
      res_in[SQ_LAT-1].bearing  = b_ff[BEAR_DLY];
   end

   // vectoring CORDIC for the bearing
   always_comb begin
      logic signed [CX_W-1:0] xe;
      logic signed [CX_W-1:0] ye;
      logic signed [CZ_W-1:0] zs;
      logic signed [CZ_W-1:0] zr;
      xe = CX_W'(dl_ff[0]) <<< CORDIC_SHIFT;
      ye = CX_W'(dl_ff[1]) <<< CORDIC_SHIFT;
      if (dl_ff[0][DELTA_W-1]) begin
         if (!dl_ff[1][DELTA_W-1]) begin
            cx_in[0] = ye;
            cy_in[0] = -xe;
            cz_in[0] = CZ_W'(HALF_PI_Q24);
         end else begin
            cx_in[0] = -ye;
            cy_in[0] = xe;
            cz_in[0] = -CZ_W'(HALF_PI_Q24);
         end
      end else begin
         cx_in[0] = xe;
         cy_in[0] = ye;
         cz_in[0] = '0;
      end
      cf_in = same_d_ff | (dl_ff[0] == '0 && dl_ff[1] == '0);

      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (!cy_ff[i][CX_W-1]) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + CZ_W'(ATAN_Q24[i]);
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - CZ_W'(ATAN_Q24[i]);
         end
      end

      zs = cz_ff[CORDIC_STAGES] + CZ_W'(BEARING_HALF);
      zr = zs >>> BEARING_SHIFT;
      if (cf_ff[CORDIC_STAGES]) begin
         b_in = '0;
      end else if (zr > CZ_W'(BEARING_LIMIT)) begin
         b_in = BEAR_W'(BEARING_LIMIT);
      end else if (zr < -CZ_W'(BEARING_LIMIT)) begin
         b_in = -BEAR_W'(BEARING_LIMIT);
      end else begin
         b_in = BEAR_W'(zr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         src_ff[0] <= source_x;
         src_ff[1] <= source_y;
         tgt_ff[0] <= target_x;
         tgt_ff[1] <= target_y;

         d1_ff  <= d1_in;
         ok1_ff <= ok1_in;

         v2_ff  <= v2_in;
         ad2_ff <= ad2_in;
         ok2_ff <= ok1_ff;

         u_ff      <= u_in;
         neg_ff[0] <= {neg_ff[0][MOD_STEPS-1:0], v2_ff[0][VW-1]};
         neg_ff[1] <= {neg_ff[1][MOD_STEPS-1:0], v2_ff[1][VW-1]};
         same_m_ff <= {same_m_ff[MOD_STEPS-1:0], same3_in};
         ok_m_ff   <= {ok_m_ff[MOD_STEPS-1:0], ok2_ff};

         r_ff      <= r_in;
         same_r_ff <= same_m_ff[MOD_STEPS];
         ok_r_ff   <= ok_m_ff[MOD_STEPS];

         dl_ff     <= dl_in;
         same_d_ff <= same_r_ff;
         ok_d_ff   <= ok_r_ff;

         sqx_ff <= $unsigned(px_in);
         sqy_ff <= $unsigned(py_in);
         n_ff   <= n_in;
         rt_ff  <= rt_in;
         res_ff <= res_in;

         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         cf_ff <= {cf_ff[CORDIC_STAGES-1:0], cf_in};
         b_ff[0] <= b_in;
         for (int k = 1; k <= BEAR_DLY; k++) begin
            b_ff[k] <= b_ff[k-1];
         end
      end
   end

   assign out_beat = res_ff[SQ_LAT-1];

endmodule

// ===== rtl/core/toroidal_distance_and_bearing.sv =====
// Shortest displacement, distance and bearing between two points on a
// wrap-around world centred on the origin.
//
// req_* carries one point pair per beat; rsp_* returns one result per beat.
// csr_* writes the world width, world height and equality tolerance (index
// 0, 1, 2); sizes are clamped to 2..8388608 on write. Write only while idle.
//
// Throughput: one pair per cycle while req_tready is high. Each pair passes
// through the per-axis wrap remainder (one quotient bit per stage) and then
// the 24-stage square root; the CORDIC bearing runs beside the root.
//
// Reset clears all valid bits and loads the register defaults (sizes 262144,
// tolerance 1). When rsp_tready is low the output register holds its beat,
// a skid register catches the next one, and only then does req_tready drop
// and the whole pipeline freeze; nothing is lost or repeated.
module toroidal_distance_and_bearing
   import tdb_pkg::*;
#(
   parameter int COORD_WIDTH   = 24,
   parameter int CORDIC_STAGES = 16,
   localparam int REQ_DATA_W   = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // source_x, source_y, target_x, target_y, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // delta_x, delta_y, distance, bearing, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // same_point, in_range
   output logic [RSP_USER_W-1:0] rsp_tuser,

   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam logic [1:0] CSR_WORLD_SIZE_X   = 2'd0;
   localparam logic [1:0] CSR_WORLD_SIZE_Y   = 2'd1;
   localparam logic [1:0] CSR_EQUAL_TOLERANCE = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = 24'd2;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = 24'd8388608;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 24'd262144;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd1;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      if (v < SIZE_MIN) begin
         return SIZE_MIN;
      end
      if (v > SIZE_MAX) begin
         return SIZE_MAX;
      end
      return v;
   endfunction

   cfg_type cfg_in, cfg_ff;
   logic    adv;
   logic    pipe_vld;
   rsp_type pipe_beat;
   rsp_type rsp_ff, skid_ff;
   logic    rsp_vld_ff, skid_vld_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_WORLD_SIZE_X:    cfg_in.size_x = clamp_size(csr_wdata);
            CSR_WORLD_SIZE_Y:    cfg_in.size_y = clamp_size(csr_wdata);
            CSR_EQUAL_TOLERANCE: cfg_in.tol    = csr_wdata[TOL_W-1:0];
            default:             cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x <= SIZE_RESET;
         cfg_ff.size_y <= SIZE_RESET;
         cfg_ff.tol    <= TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   tdb_pipe #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .source_x  ($signed(req_tdata[COORD_WIDTH-1:0])),
      .source_y  ($signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
      .target_x  ($signed(req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
      .target_y  ($signed(req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH])),
      .cfg       (cfg_ff),
      .out_valid (pipe_vld),
      .out_beat  (pipe_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (rsp_vld_ff && !rsp_tready) begin
         skid_vld_ff <= pipe_vld;
      end else begin
         rsp_vld_ff <= pipe_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            rsp_ff <= skid_ff;
         end
      end else if (rsp_vld_ff && !rsp_tready) begin
         skid_ff <= pipe_beat;
      end else begin
         rsp_ff <= pipe_beat;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.bearing, rsp_ff.distance,
                        rsp_ff.delta_y, rsp_ff.delta_x};
   assign rsp_tuser  = {rsp_ff.in_range, rsp_ff.same_point};

endmodule

// ===== tb/tdb_tb_pkg.sv =====
package tdb_tb_pkg;

   typedef enum logic [1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_TOL    = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_e;

   localparam int SIZE_FLOOR = 2;
   localparam int SIZE_CEIL  = 8388608;
   localparam int RESET_SIZE = 262144;
   localparam int RESET_TOL  = 1;

endpackage

// ===== tb/tdb_bearing_checker.sv =====
module tdb_bearing_checker
   import tdb_pkg::*;
   import tdb_tb_pkg::*;
#(
   parameter int COORD_WIDTH   = 24,
   parameter int CORDIC_STAGES = 16,
   localparam int REQ_DATA_W   = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // source_x, source_y, target_x, target_y, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // delta_x, delta_y, distance, bearing, zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   // same_point, in_range
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [SIZE_W-1:0]     csr_wdata,
   output int                    mismatch_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [SIZE_W-1:0] size_x_cfg = SIZE_W'(RESET_SIZE);
   logic [SIZE_W-1:0] size_y_cfg = SIZE_W'(RESET_SIZE);
   logic [TOL_W-1:0]  tol_cfg    = TOL_W'(RESET_TOL);
   rsp_type           answers_q[$];
   int                miss_count = 0;

   longint atan_step [ANG_TABLE_LEN] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   function automatic longint span_of(logic [SIZE_W-1:0] raw);
      if (raw < SIZE_FLOOR) return SIZE_FLOOR;
      if (raw > SIZE_CEIL) return SIZE_CEIL;
      return longint'(raw);
   endfunction

   function automatic longint wrap_disp(longint d, longint span);
      longint lo, r;
      lo = -(span / 2);
      r = (d - lo) % span;
      if (r < 0) r += span;
      return r + lo;
   endfunction

   function automatic logic on_world(longint v, longint span);
      longint lo;
      lo = -(span / 2);
      return v >= lo && v < lo + span;
   endfunction

   function automatic longint unsigned root_nearest(longint unsigned s);
      longint unsigned r, b, n;
      r = 0;
      b = 64'd1 << 62;
      n = s;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic longint bearing_of(longint dy, longint dx);
      longint x, y, z, t, xs, ys, q;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI_Q24;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI_Q24;
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < ANG_TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_step[i];
         end else begin
            x -= ys; y += xs; z -= atan_step[i];
         end
      end
      q = (z + BEARING_HALF) >>> BEARING_SHIFT;
      if (q > BEARING_LIMIT) q = BEARING_LIMIT;
      if (q < -BEARING_LIMIT) q = -BEARING_LIMIT;
      return q;
   endfunction

   function automatic rsp_type predict_geometry(logic [REQ_DATA_W-1:0] data);
      longint sx, sy, tx, ty, szx, szy, dx, dy, ang, tol, ax, ay;
      longint unsigned root_len;
      rsp_type r;
      sx = $signed(data[0 +: COORD_WIDTH]);
      sy = $signed(data[COORD_WIDTH +: COORD_WIDTH]);
      tx = $signed(data[2 * COORD_WIDTH +: COORD_WIDTH]);
      ty = $signed(data[3 * COORD_WIDTH +: COORD_WIDTH]);
      szx = span_of(size_x_cfg);
      szy = span_of(size_y_cfg);
      tol = longint'(tol_cfg);
      dx = wrap_disp(tx - sx, szx);
      dy = wrap_disp(ty - sy, szy);
      root_len = root_nearest(longint'(dx * dx + dy * dy));
      if (root_len > DIST_MAX) root_len = DIST_MAX;
      ax = (tx - sx < 0) ? sx - tx : tx - sx;
      ay = (ty - sy < 0) ? sy - ty : ty - sy;
      r.same_point = ax < tol && ay < tol;
      r.in_range = on_world(sx, szx) && on_world(tx, szx) &&
                   on_world(sy, szy) && on_world(ty, szy);
      ang = 0;
      if (!r.same_point && !(dx == 0 && dy == 0)) ang = bearing_of(dy, dx);
      r.delta_x = dx[DELTA_W-1:0];
      r.delta_y = dy[DELTA_W-1:0];
      r.distance = root_len[DIST_W-1:0];
      r.bearing = ang[BEAR_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : observe
      rsp_type want, got;
      if (reset) begin
         size_x_cfg = SIZE_W'(RESET_SIZE);
         size_y_cfg = SIZE_W'(RESET_SIZE);
         tol_cfg = TOL_W'(RESET_TOL);
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_SIZE_X: size_x_cfg = csr_wdata;
               CSR_SIZE_Y: size_y_cfg = csr_wdata;
               CSR_TOL:    tol_cfg = csr_wdata[TOL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) answers_q.push_back(predict_geometry(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.delta_x = rsp_tdata[0 +: DELTA_W];
            got.delta_y = rsp_tdata[DELTA_W +: DELTA_W];
            got.distance = rsp_tdata[2 * DELTA_W +: DIST_W];
            got.bearing = rsp_tdata[2 * DELTA_W + DIST_W +: BEAR_W];
            got.same_point = rsp_tuser[0];
            got.in_range = rsp_tuser[1];
            if (answers_q.size() == 0) begin
               miss_count++;
               if (miss_count <= REPORT_LIMIT)
                  $display("%0t: unexpected beat tdata %h tuser %b",
                           $time, rsp_tdata, rsp_tuser);
            end else begin
               want = answers_q.pop_front();
               if (got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
                   got.distance !== want.distance || got.bearing !== want.bearing ||
                   got.same_point !== want.same_point || got.in_range !== want.in_range) begin
                  miss_count++;
                  if (miss_count <= REPORT_LIMIT) begin
                     $display("%0t: exp dx %0d dy %0d dist %0d brg %0d same %b in %b",
                              $time, want.delta_x, want.delta_y, want.distance,
                              want.bearing, want.same_point, want.in_range);
                     $display("%0t: got dx %0d dy %0d dist %0d brg %0d same %b in %b",
                              $time, got.delta_x, got.delta_y, got.distance,
                              got.bearing, got.same_point, got.in_range);
                  end
               end
            end
         end
      end
      mismatch_count <= miss_count;
      outstanding <= answers_q.size();
   end

endmodule

// ===== tb/tb_toroidal_distance_and_bearing.sv =====
module tb_toroidal_distance_and_bearing;
   timeunit 1ns;
   timeprecision 1ps;
   import tdb_pkg::*;
   import tdb_tb_pkg::*;

   localparam int COORD_W    = 24;
   localparam int STAGES     = 16;
   localparam int REQ_W      = ((4 * COORD_W + 7) / 8) * 8;
   localparam int PERIOD     = 12;
   localparam int LATENCY    = 57;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 200;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_MASK, FLOW_SPARSE, FLOW_BLOCKED} flow_mode_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_addr = '0;
   logic [SIZE_W-1:0]     csr_wdata = '0;
   int                    mismatch_count;
   int                    outstanding;

   int unsigned           span_x = RESET_SIZE;
   int unsigned           span_y = RESET_SIZE;
   int unsigned           tol_now = RESET_TOL;
   int                    burst_left = 0;
   int                    idle_cycles = 0;
   flow_mode_e            flow_mode = FLOW_FREE;
   logic [31:0]           flow_mask = '1;
   logic [5:0]            flow_phase = '0;

   toroidal_distance_and_bearing #(
      .COORD_WIDTH(COORD_W),
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   tdb_bearing_checker #(
      .COORD_WIDTH(COORD_W),
      .CORDIC_STAGES(STAGES)
   ) bearing_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   always #(PERIOD / 2) clock = ~clock;

   // receiver back-pressure, new pattern each time flow_phase wraps to zero
   always @(posedge clock) begin
      flow_phase <= flow_phase + 6'd1;
      if (flow_phase == '0) begin
         flow_mode <= flow_mode_e'($urandom_range(0, 3));
         flow_mask <= $urandom;
      end
      case (flow_mode)
         FLOW_FREE:   rsp_tready <= 1'b1;
         FLOW_MASK:   rsp_tready <= flow_mask[flow_phase[4:0]];
         FLOW_SPARSE: rsp_tready <= flow_phase[2:0] == 3'd0;
         default:     rsp_tready <= flow_phase[5:4] != 2'd0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("toroidal_distance_and_bearing: mismatch");
         $finish;
      end
   end

   function automatic int unsigned span_of(logic [SIZE_W-1:0] raw);
      if (raw < SIZE_FLOOR) return SIZE_FLOOR;
      if (raw > SIZE_CEIL) return SIZE_CEIL;
      return int'(raw);
   endfunction

   function automatic logic [REQ_W-1:0] pair(int sx, int sy, int tx, int ty);
      return REQ_W'({COORD_W'(ty), COORD_W'(tx), COORD_W'(sy), COORD_W'(sx)});
   endfunction

   function automatic int pick_coord(int unsigned span);
      int lo;
      int unsigned sel;
      lo = -int'(span / 2);
      sel = $urandom_range(0, 99);
      if (sel < 65) return lo + int'($urandom_range(0, span - 1));
      if (sel < 85) begin
         case ($urandom_range(0, 3))
            0: return lo - 1 + int'($urandom_range(0, 2));
            1: return lo + int'(span) - 2 + int'($urandom_range(0, 2));
            2: return $urandom_range(0, 1) ? -8388608 : 8388607;
            default: return int'($urandom_range(0, 255)) - 128;
         endcase
      end
      return int'({{8{1'b0}}, COORD_W'($urandom)}) - (1 << (COORD_W - 1));
   endfunction

   function automatic logic [REQ_W-1:0] random_pair();
      int sx, sy, tx, ty, reach;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      sx = pick_coord(span_x);
      sy = pick_coord(span_y);
      if (sel < 75) begin
         tx = pick_coord(span_x);
         ty = pick_coord(span_y);
      end else if (sel < 92) begin
         reach = int'(tol_now) + 1;
         tx = sx + int'($urandom_range(0, 2 * reach)) - reach;
         ty = sy + int'($urandom_range(0, 2 * reach)) - reach;
      end else begin
         return REQ_W'({$urandom, $urandom, $urandom});
      end
      return pair(sx, sy, tx, ty);
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return SIZE_W'($urandom_range(2, 4096));
      if (sel < 8) return SIZE_W'($urandom_range(SIZE_FLOOR, SIZE_CEIL));
      return SIZE_W'($urandom);
   endfunction

   function automatic logic [TOL_W-1:0] random_tol();
      if ($urandom_range(0, 9) < 7) return TOL_W'($urandom_range(0, 64));
      return TOL_W'($urandom);
   endfunction

   task automatic push_pair(input logic [REQ_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // drop valid and hold until every predicted result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] wx, input logic [SIZE_W-1:0] wy,
                            input logic [TOL_W-1:0] wt);
      csr_we <= 1'b1;
      csr_addr <= CSR_SIZE_X;
      csr_wdata <= wx;
      @(posedge clock);
      csr_addr <= CSR_SIZE_Y;
      csr_wdata <= wy;
      @(posedge clock);
      csr_addr <= CSR_TOL;
      csr_wdata <= SIZE_W'(wt);
      @(posedge clock);
      csr_addr <= CSR_SPARE;
      csr_wdata <= SIZE_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      span_x = span_of(wx);
      span_y = span_of(wy);
      tol_now = wt;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_pair(pair(0, 0, 0, 0));
      push_pair(pair(100, -50, 100, -50));
      push_pair(pair(0, 0, 1, 0));
      push_pair(pair(0, 0, -256, 0));
      push_pair(pair(0, 0, -256, -1));
      push_pair(pair(0, 0, 0, 512));
      push_pair(pair(0, 0, 0, -512));
      push_pair(pair(0, 0, 300, 300));
      push_pair(pair(0, 0, -300, 300));
      push_pair(pair(0, 0, 300, -300));
      push_pair(pair(131000, 0, -131000, 0));
      push_pair(pair(0, -131072, 0, 131071));
      push_pair(pair(-131072, -131072, 131071, 131071));
      push_pair(pair(131072, 0, 0, 0));
      push_pair(pair(-131072, 5, 131072, 5));
      push_pair(pair(0, 0, 131072, 0));
      push_pair(pair(0, 0, -131072, -131072));
      push_pair(pair(-8388608, -8388608, 8388607, 8388607));
      push_pair(pair(8388607, 8388607, -8388608, -8388608));
      push_pair(pair(-8388608, 8388607, -8388608, 8388607));
      for (int n = 0; n < PHASE_LEN; n++) push_pair(random_pair());
      drain();

      for (int ph = 1; ph < PHASES; ph++) begin
         case (ph)
            1: configure(24'd0, 24'd1, 16'd0);
            2: configure(24'd3, 24'd5, 16'd2);
            3: configure(24'd8388608, 24'd8388608, 16'hFFFF);
            4: configure(24'hFFFFFF, 24'd2, 16'd40);
            default: configure(random_size(), random_size(), random_tol());
         endcase
         if (ph == 1) push_pair(pair(0, 0, 0, 0));
         for (int n = 0; n < PHASE_LEN; n++) push_pair(random_pair());
         drain();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("toroidal_distance_and_bearing: match");
      else
         $display("toroidal_distance_and_bearing: mismatch");
      $finish;
   end

endmodule
